/* rtl/i2cbe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine: shared types and constants
// Command codes, sequencer step codes, queue entry layout and register map.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

   // Width of the phase length registers.
   localparam int unsigned CFG_PHASE_BITS = 10;
   // Bit counter width; counts up to eight bits of one byte.
   localparam int unsigned BIT_COUNT_BITS = 4;
   // Command queue between the front and the sequencer.
   localparam int unsigned Q_DEPTH        = 4;
   localparam int unsigned Q_PTR_BITS     = 2;
   localparam int unsigned Q_COUNT_BITS   = 3;

   // Register map of the configuration port.
   localparam int unsigned CSR_ADDR_BITS  = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_SHORT = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_LONG  = 3'd4;

   // Reset values of the phase registers.
   localparam logic [CFG_PHASE_BITS-1:0] SHORT_RESET = 10'd1;
   localparam logic [CFG_PHASE_BITS-1:0] LONG_RESET  = 10'd5;

   // Bus commands carried by the action field.
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   // Sequencer steps; the meaning of each step depends on the command.
   typedef enum logic [3:0] {
      STEP_IDLE = 4'd0,
      STEP_1    = 4'd1,
      STEP_2    = 4'd2,
      STEP_3    = 4'd3,
      STEP_4    = 4'd4,
      STEP_5    = 4'd5,
      STEP_6    = 4'd6,
      STEP_7    = 4'd7,
      STEP_8    = 4'd8,
      STEP_9    = 4'd9,
      STEP_10   = 4'd10
   } step_type;

   // One classified tick as it travels through the queue.
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       send_ack;
      logic       sda_in;
   } tick_item_type;

   // Phase lengths handed to the sequencer.
   typedef struct packed {
      logic [CFG_PHASE_BITS-1:0] short_ticks;
      logic [CFG_PHASE_BITS-1:0] long_ticks;
   } phase_cfg_type;

endpackage

/* rtl/i2cbe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine: front stage
// Accepts input items, decodes the action code into a command and registers
// the classified item for the command queue.
// ----------------------------------------------------------------------------
module i2cbe_front
   import i2cbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [2:0]    action,
   input  logic [7:0]    data_byte,
   input  logic          send_ack,
   input  logic          sda_in,
   output logic          out_valid,
   input  logic          out_ready,
   output tick_item_type out_item
);

   logic          valid_ff;
   logic          valid_in;
   tick_item_type item_ff;
   tick_item_type item_in;
   cmd_type       cmd_dec;

   // The stage takes a new item whenever it is empty or being emptied.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // Unknown action codes are treated as no command.
   always_comb begin
      unique case (action)
         CMD_START: cmd_dec = CMD_START;
         CMD_STOP:  cmd_dec = CMD_STOP;
         CMD_WRITE: cmd_dec = CMD_WRITE;
         CMD_READ:  cmd_dec = CMD_READ;
         default:   cmd_dec = CMD_NONE;
      endcase
   end

   always_comb begin
      item_in.cmd       = cmd_dec;
      item_in.data_byte = data_byte;
      item_in.send_ack  = send_ack;
      item_in.sda_in    = sda_in;
      valid_in          = in_ready ? in_valid : valid_ff;
   end

   // Control flag is reset; the payload only loads on acceptance.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/i2cbe_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine: command queue
// Short first-word-fall-through queue that decouples the front stage from
// the pin sequencer.
// ----------------------------------------------------------------------------
module i2cbe_fifo
   import i2cbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  tick_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output tick_item_type pop_item
);

   tick_item_type             store_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]     wr_ptr_ff;
   logic [Q_PTR_BITS-1:0]     wr_ptr_in;
   logic [Q_PTR_BITS-1:0]     rd_ptr_ff;
   logic [Q_PTR_BITS-1:0]     rd_ptr_in;
   logic [Q_COUNT_BITS-1:0]   count_ff;
   logic [Q_COUNT_BITS-1:0]   count_in;
   logic                      do_push;
   logic                      do_pop;

   assign push_ready = (count_ff != Q_COUNT_BITS'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/i2cbe_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine: pin sequencer
// Walks the step sequence of the current command one tick per item, holds
// each step for its phase length and registers one result per tick.
// ----------------------------------------------------------------------------
module i2cbe_back
   import i2cbe_pkg::*;
#(
   parameter int unsigned PHASE_COUNTER_BITS = 10
)
(
   input  logic          clock,
   input  logic          reset,
   input  phase_cfg_type phase_cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  tick_item_type in_item,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [15:0]   rsp_tdata
);

   logic                          pop;
   step_type                      step_ff,      step_in;
   logic [PHASE_COUNTER_BITS-1:0] phase_ff,     phase_in;
   logic [PHASE_COUNTER_BITS-1:0] phase_dec;
   logic [PHASE_COUNTER_BITS-1:0] phase_load;
   cmd_type                       cmd_ff,       cmd_in;
   logic [7:0]                    shift_ff,     shift_in;
   logic [BIT_COUNT_BITS-1:0]     bit_cnt_ff,   bit_cnt_in;
   logic [BIT_COUNT_BITS-1:0]     bit_cnt_inc;
   logic                          scl_ff,       scl_in;
   logic                          sda_ff,       sda_in;
   logic [1:0]                    ack_flag_ff,  ack_flag_in;
   logic                          ack_choice_ff, ack_choice_in;
   logic [7:0]                    last_read_ff, last_read_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [15:0]                   rsp_data_ff,  rsp_data_in;
   logic                          done;
   logic                          enter;
   logic                          long_step;
   logic [CFG_PHASE_BITS-1:0]     dur_raw;
   logic [CFG_PHASE_BITS-1:0]     dur_m1;

   // A tick is processed whenever the result register is free or draining.
   assign in_ready   = !rsp_valid_ff || rsp_tready;
   assign pop        = in_valid && in_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign bit_cnt_inc = bit_cnt_ff + 1'b1;
   assign phase_dec   = phase_ff - 1'b1;

   // Next step: command start, hold countdown or the work on leaving a step.
   always_comb begin
      step_in       = step_ff;
      cmd_in        = cmd_ff;
      shift_in      = shift_ff;
      bit_cnt_in    = bit_cnt_ff;
      ack_flag_in   = ack_flag_ff;
      ack_choice_in = ack_choice_ff;
      last_read_in  = last_read_ff;
      done          = 1'b0;
      enter         = 1'b0;
      if (pop) begin
         if (step_ff == STEP_IDLE) begin
            if (in_item.cmd != CMD_NONE) begin
               cmd_in     = in_item.cmd;
               bit_cnt_in = '0;
               if (in_item.cmd == CMD_WRITE) begin
                  shift_in    = in_item.data_byte;
                  ack_flag_in = 2'b00;
               end else if (in_item.cmd == CMD_READ) begin
                  shift_in      = 8'h00;
                  ack_choice_in = in_item.send_ack;
               end
               step_in = STEP_1;
               enter   = 1'b1;
            end
         end else if (phase_ff != '0) begin
            step_in = step_ff;
         end else begin
            unique case (cmd_ff)
               CMD_START, CMD_STOP: begin
                  step_in = (step_ff < STEP_3) ? step_type'(step_ff + 4'd1) : STEP_IDLE;
               end
               CMD_WRITE: begin
                  if (step_ff == STEP_3) begin
                     // One data bit sent; move to the next bit or to the ack.
                     shift_in   = {shift_ff[6:0], 1'b0};
                     bit_cnt_in = bit_cnt_inc;
                     step_in    = (bit_cnt_inc < BIT_COUNT_BITS'(8)) ? STEP_1 : STEP_4;
                  end else if (step_ff == STEP_6) begin
                     ack_flag_in = {1'b0, ~in_item.sda_in};
                     step_in     = STEP_7;
                  end else if (step_ff == STEP_7) begin
                     // Acknowledged: finish. Otherwise issue a stop.
                     if (ack_flag_ff[0]) begin
                        step_in = STEP_IDLE;
                     end else begin
                        ack_flag_in = {1'b1, ack_flag_ff[0]};
                        step_in     = STEP_8;
                     end
                  end else begin
                     step_in = (step_ff < STEP_10) ? step_type'(step_ff + 4'd1) : STEP_IDLE;
                  end
               end
               CMD_READ: begin
                  if (step_ff == STEP_1) begin
                     shift_in = {shift_ff[6:0], in_item.sda_in};
                     step_in  = STEP_2;
                  end else if (step_ff == STEP_3) begin
                     bit_cnt_in = bit_cnt_inc;
                     if (bit_cnt_inc < BIT_COUNT_BITS'(8)) begin
                        step_in = STEP_1;
                     end else begin
                        last_read_in = shift_ff;
                        step_in      = STEP_4;
                     end
                  end else begin
                     step_in = (step_ff < STEP_8) ? step_type'(step_ff + 4'd1) : STEP_IDLE;
                  end
               end
               default: begin
                  step_in = STEP_IDLE;
               end
            endcase
            if (step_in == STEP_IDLE) begin
               done = 1'b1;
            end else begin
               enter = 1'b1;
            end
         end
      end
   end

   // Pin levels applied on entering a step, and whether the step is long.
   always_comb begin
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      long_step = 1'b0;
      if (enter) begin
         unique case (cmd_in)
            CMD_START: begin
               if (step_in == STEP_1) begin
                  scl_in = 1'b1; long_step = 1'b1;
               end else if (step_in == STEP_2) begin
                  sda_in = 1'b1;
               end else if (step_in == STEP_3) begin
                  sda_in = 1'b0; long_step = 1'b1;
               end
            end
            CMD_STOP: begin
               if (step_in == STEP_1) begin
                  scl_in = 1'b1; long_step = 1'b1;
               end else if (step_in == STEP_2) begin
                  sda_in = 1'b0;
               end else if (step_in == STEP_3) begin
                  sda_in = 1'b1; long_step = 1'b1;
               end
            end
            CMD_WRITE: begin
               unique case (step_in)
                  STEP_1:  scl_in = 1'b0;
                  STEP_2:  sda_in = shift_in[7];
                  STEP_3:  scl_in = 1'b1;
                  STEP_4:  scl_in = 1'b0;
                  STEP_5:  sda_in = 1'b1;
                  STEP_6:  begin scl_in = 1'b1; long_step = 1'b1; end
                  STEP_7:  scl_in = 1'b0;
                  STEP_8:  begin scl_in = 1'b1; long_step = 1'b1; end
                  STEP_9:  sda_in = 1'b0;
                  STEP_10: begin sda_in = 1'b1; long_step = 1'b1; end
                  default: scl_in = scl_ff;
               endcase
            end
            CMD_READ: begin
               unique case (step_in)
                  STEP_1:  scl_in = 1'b1;
                  STEP_3:  scl_in = 1'b0;
                  STEP_4:  scl_in = 1'b0;
                  STEP_5:  sda_in = ~ack_choice_in;
                  STEP_6:  begin scl_in = 1'b1; long_step = 1'b1; end
                  STEP_7:  scl_in = 1'b0;
                  STEP_8:  sda_in = 1'b1;
                  default: scl_in = scl_ff;
               endcase
            end
            default: begin
               scl_in = scl_ff;
            end
         endcase
      end
   end

   // Phase length: a zero register counts as one tick.
   assign dur_raw = long_step ? phase_cfg.long_ticks : phase_cfg.short_ticks;
   assign dur_m1  = (dur_raw == '0) ? '0 : dur_raw - 1'b1;

   // Saturate at the largest length the counter can hold.
   generate
      if (PHASE_COUNTER_BITS > CFG_PHASE_BITS) begin : g_wide
         assign phase_load = {{(PHASE_COUNTER_BITS - CFG_PHASE_BITS){1'b0}}, dur_m1};
      end else if (PHASE_COUNTER_BITS == CFG_PHASE_BITS) begin : g_equal
         assign phase_load = dur_m1;
      end else begin : g_narrow
         localparam logic [CFG_PHASE_BITS-1:0] PhaseCap =
            CFG_PHASE_BITS'((1 << PHASE_COUNTER_BITS) - 1);
         assign phase_load = (dur_m1 > PhaseCap) ? '1 : dur_m1[PHASE_COUNTER_BITS-1:0];
      end
   endgenerate

   // Phase counter update.
   always_comb begin
      phase_in = phase_ff;
      if (enter) begin
         phase_in = phase_load;
      end else if (pop && step_ff != STEP_IDLE && phase_ff != '0) begin
         phase_in = phase_dec;
      end
   end

   // Result word, highest bit first.
   always_comb begin
      rsp_data_in = {2'b00, ack_flag_in[1], ack_flag_in[0], last_read_in,
                     done, (step_in != STEP_IDLE), sda_in, scl_in};
      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_IDLE;
         phase_ff      <= '0;
         cmd_ff        <= CMD_NONE;
         shift_ff      <= '0;
         bit_cnt_ff    <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ack_flag_ff   <= '0;
         ack_choice_ff <= 1'b0;
         last_read_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         phase_ff      <= phase_in;
         cmd_ff        <= cmd_in;
         shift_ff      <= shift_in;
         bit_cnt_ff    <= bit_cnt_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         ack_flag_ff   <= ack_flag_in;
         ack_choice_ff <= ack_choice_in;
         last_read_ff  <= last_read_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload loads with each processed tick.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* rtl/i2c_master_byte_engine.sv */
`timescale 1ns / 1ps
// Path: an accepted item passes the front register, the command queue and the
// result register before its result is offered.
// Throughput: one item per cycle unless rsp_tready stalls; the pin sequencer then retires one tick each cycle.
// Reset: synchronous, active high; lines released high, sequencer idle,
// short phase 1 tick, long phase 5 ticks, queue empty.
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master: start, stop, byte write with ack check and byte
// read with master ack, with programmable short and long phase lengths.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
   import i2cbe_pkg::*;
#(
   parameter int unsigned PHASE_COUNTER_BITS = 10
)
(
   input  logic                     clock,
   input  logic                     reset,
   // Input items.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [2:0] action, [10:3] data_byte, [11] send_ack, [12] sda_in, [15:13] zero
   input  logic [15:0]              req_tdata,
   // Results.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
   // [12] ack_received, [13] stopped_on_nack, [15:14] zero
   output logic [15:0]              rsp_tdata,
   // Configuration port.
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   phase_cfg_type cfg_ff;
   phase_cfg_type cfg_in;
   logic          csr_write;
   logic          front_valid;
   logic          front_ready;
   tick_item_type front_item;
   logic          queue_valid;
   logic          queue_ready;
   tick_item_type queue_item;

   // Register file.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         if (csr_paddr == CSR_ADDR_SHORT) begin
            cfg_in.short_ticks = csr_pwdata[CFG_PHASE_BITS-1:0];
         end else if (csr_paddr == CSR_ADDR_LONG) begin
            cfg_in.long_ticks = csr_pwdata[CFG_PHASE_BITS-1:0];
         end
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_ADDR_SHORT: csr_prdata = {{(32 - CFG_PHASE_BITS){1'b0}}, cfg_ff.short_ticks};
         CSR_ADDR_LONG:  csr_prdata = {{(32 - CFG_PHASE_BITS){1'b0}}, cfg_ff.long_ticks};
         default:        csr_prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_ticks <= SHORT_RESET;
         cfg_ff.long_ticks  <= LONG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and classify.
   i2cbe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .action    (req_tdata[2:0]),
      .data_byte (req_tdata[10:3]),
      .send_ack  (req_tdata[11]),
      .sda_in    (req_tdata[12]),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   // Queue between front and sequencer.
   i2cbe_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   // Back: pin sequencer and result register.
   i2cbe_back #(
      .PHASE_COUNTER_BITS (PHASE_COUNTER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .phase_cfg  (cfg_ff),
      .in_valid   (queue_valid),
      .in_ready   (queue_ready),
      .in_item    (queue_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/i2cbe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine: port checker
// Watches the top-level ports for result, status and register consistency.
// ----------------------------------------------------------------------------
module i2cbe_checker
   import i2cbe_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [15:0]              rsp_tdata,
   input logic                     csr_psel,
   input logic                     csr_penable,
   input logic                     csr_pwrite,
   input logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [31:0]              csr_pwdata,
   input logic [31:0]              csr_prdata,
   input logic                     csr_pready
);

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or withdrawn");

   // A finishing tick never reports busy at the same time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[3] && rsp_tdata[2]))
      else $error("done and busy reported together");

   // No result is offered straight after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // A short phase write reads back on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CSR_ADDR_SHORT
      |=> csr_paddr != CSR_ADDR_SHORT ||
          csr_prdata[CFG_PHASE_BITS-1:0] == $past(csr_pwdata[CFG_PHASE_BITS-1:0]))
      else $error("short phase register read-back mismatch");

endmodule

bind i2c_master_byte_engine i2cbe_checker u_i2cbe_checker (.*);
